### rtl/core/bhgs_pkg.sv
package bhgs_pkg;

   // Grid side default; the top level takes it as its MAX_SIDE parameter.
   localparam int unsigned MAX_SIDE_DEFAULT = 1025;

   // Field widths
   localparam int unsigned VERTEX_W = 11;
   localparam int unsigned INDEX_W  = 11;
   localparam int unsigned HEIGHT_W = 16;
   localparam int unsigned FRAC_W   = 17;
   localparam int unsigned SCALE_W  = 16;
   localparam int unsigned RESULT_W = 32;

   // Q1.16 one
   localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h1_0000;

   // Item kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // CSR map
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_VERTICES  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_Z_VERTICES  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_SCALE = 2'd2;

   // CSR reset values
   localparam logic [VERTEX_W-1:0] VERTICES_RESET    = 11'd1025;
   localparam logic [SCALE_W-1:0]  LEVEL_SCALE_RESET = 16'd256;

endpackage

### rtl/core/bhgs_if.sv
interface bhgs_req_if import bhgs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                kind;
   logic [INDEX_W-1:0]  row;
   logic [INDEX_W-1:0]  column;
   logic [HEIGHT_W-1:0] raw_height;
   logic [FRAC_W-1:0]   x_fraction;
   logic [FRAC_W-1:0]   z_fraction;

   modport source (output valid, kind, row, column, raw_height, x_fraction, z_fraction,
                   input ready);
   modport sink   (input valid, kind, row, column, raw_height, x_fraction, z_fraction,
                   output ready);
endinterface

interface bhgs_rsp_if import bhgs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [RESULT_W-1:0] height;

   modport source (output valid, height, input ready);
   modport sink   (input valid, height, output ready);
endinterface

interface bhgs_csr_if import bhgs_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/bhgs_ram.sv
module bhgs_ram #(
   parameter  int unsigned WIDTH  = 16,
   parameter  int unsigned DEPTH  = 1024,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wr_data,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/bilinear_height_grid_sampler.sv
// Channel  Dir  Transaction                         Handshake
// req_ch   in   write sample / height query         valid & ready
// rsp_ch   out  one scaled height per query         valid & ready
// csr_ch   in   register write (index, data)        valid & ready, ready always high
//
// A write transaction goes straight into the grid RAM.
// A query holds the block through two corner/weight steps, four reads
// through the single grid RAM port, and ten passes through one shared 32x17
// multiplier with a 49-bit accumulator.
// Synchronous active-high reset clears the sequencer, result valid and CSRs;
// the grid RAM is not cleared and holds garbage until written.
// A new transaction is taken while a result waits on rsp_ch; a query that
// finishes before that result is taken holds in its last step.
module bilinear_height_grid_sampler import bhgs_pkg::*; #(
   parameter int unsigned MAX_SIDE = MAX_SIDE_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   bhgs_req_if.sink  req_ch,
   bhgs_rsp_if.source rsp_ch,
   bhgs_csr_if.sink  csr_ch
);

   localparam int unsigned IDX_W   = $clog2(MAX_SIDE);
   localparam int unsigned DEPTH   = MAX_SIDE * MAX_SIDE;
   localparam int unsigned ADDR_W  = $clog2(DEPTH);
   localparam int unsigned MUL_A_W = 32;
   localparam int unsigned MUL_B_W = FRAC_W;
   localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
   localparam int unsigned ACC_W   = PROD_W;

   // Sequencer, one-hot
   typedef enum logic [12:0] {
      ST_IDLE = 13'h0001,
      ST_LOCX = 13'h0002,  // x corner and weight
      ST_LOCZ = 13'h0004,  // z corner and weight
      ST_RD00 = 13'h0008,  // issue read (z0, x0)
      ST_RD01 = 13'h0010,  // issue (z0, x1), take g00
      ST_RD10 = 13'h0020,  // issue (z1, x0), take g01
      ST_RD11 = 13'h0040,  // issue (z1, x1), take g10
      ST_X11  = 13'h0080,  // take g11
      ST_Z0   = 13'h0100,  // z blend, lower row
      ST_Z1   = 13'h0200,  // z blend, upper row
      ST_S0   = 13'h0400,  // scale, upper 32 bits of h
      ST_S1   = 13'h0800,  // scale, lower 16 bits of h
      ST_DONE = 13'h1000   // hand result to output register
   } state_type;

   function automatic logic [IDX_W-1:0] cells_of(input logic [VERTEX_W-1:0] v);
      int unsigned vv;
      vv = 32'(v);
      if (vv < 2) begin
         vv = 2;
      end else if (vv > MAX_SIDE) begin
         vv = MAX_SIDE;
      end
      return IDX_W'(vv - 1);
   endfunction

   // Fixed row stride of MAX_SIDE entries
   function automatic logic [ADDR_W-1:0] grid_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
      return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_SIDE) + ADDR_W'(c));
   endfunction

   state_type state_ff, state_in;

   logic [VERTEX_W-1:0] x_vertices_ff, x_vertices_in;
   logic [VERTEX_W-1:0] z_vertices_ff, z_vertices_in;
   logic [SCALE_W-1:0]  level_scale_ff, level_scale_in;

   logic [FRAC_W-1:0]   xf_ff, xf_in, zf_ff, zf_in;
   logic [IDX_W-1:0]    ix0_ff, ix0_in, ix1_ff, ix1_in;
   logic [IDX_W-1:0]    iz0_ff, iz0_in, iz1_ff, iz1_in;
   logic [15:0]         kx_ff, kx_in, kz_ff, kz_in;
   logic [31:0]         h0_ff, h0_in, h1_ff, h1_in;
   logic [15:0]         h_lo_ff, h_lo_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [RESULT_W-1:0] height_ff, height_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0]    x_cells, z_cells, loc_cells;
   logic [IDX_W-1:0]    loc_lo, loc_lo_c, loc_hi;
   logic [FRAC_W-1:0]   kx_inv, kz_inv;
   logic [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [PROD_W-1:0]   mul_p;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_addr;
   logic [HEIGHT_W-1:0] ram_rd;

   logic                req_fire, out_free, wr_in_range;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.height = height_ff;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign wr_in_range = (32'(req_ch.row) < MAX_SIDE) && (32'(req_ch.column) < MAX_SIDE);

   assign x_cells = cells_of(x_vertices_ff);
   assign z_cells = cells_of(z_vertices_ff);
   assign kx_inv  = ONE_Q16 - {1'b0, kx_ff};
   assign kz_inv  = ONE_Q16 - {1'b0, kz_ff};

   // Shared multiplier
   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Corner split of fraction * cells: integer part, then upper corner clamped
   assign loc_cells = (state_ff == ST_LOCX) ? x_cells : z_cells;
   assign loc_lo    = mul_p[16 +: IDX_W];
   assign loc_lo_c  = (loc_lo > loc_cells) ? loc_cells : loc_lo;
   assign loc_hi    = (loc_lo_c == loc_cells) ? loc_cells : IDX_W'(loc_lo_c + 1'b1);

   bhgs_ram #(
      .WIDTH (HEIGHT_W),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (req_ch.raw_height),
      .rd_data (ram_rd)
   );

   // Operand select and grid port
   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      ram_we   = 1'b0;
      ram_addr = grid_addr(IDX_W'(req_ch.row), IDX_W'(req_ch.column));
      case (state_ff)
         ST_IDLE: begin
            ram_we = req_fire && (req_ch.kind == KIND_WRITE) && wr_in_range;
         end
         ST_LOCX: begin
            mul_a = MUL_A_W'(xf_ff);
            mul_b = MUL_B_W'(x_cells);
         end
         ST_LOCZ: begin
            mul_a = MUL_A_W'(zf_ff);
            mul_b = MUL_B_W'(z_cells);
         end
         ST_RD00: begin
            ram_addr = grid_addr(iz0_ff, ix0_ff);
         end
         ST_RD01: begin
            ram_addr = grid_addr(iz0_ff, ix1_ff);
            mul_a    = MUL_A_W'(ram_rd);
            mul_b    = kx_inv;
         end
         ST_RD10: begin
            ram_addr = grid_addr(iz1_ff, ix0_ff);
            mul_a    = MUL_A_W'(ram_rd);
            mul_b    = {1'b0, kx_ff};
         end
         ST_RD11: begin
            ram_addr = grid_addr(iz1_ff, ix1_ff);
            mul_a    = MUL_A_W'(ram_rd);
            mul_b    = kx_inv;
         end
         ST_X11: begin
            mul_a = MUL_A_W'(ram_rd);
            mul_b = {1'b0, kx_ff};
         end
         ST_Z0: begin
            mul_a = h0_ff;
            mul_b = kz_inv;
         end
         ST_Z1: begin
            mul_a = h1_ff;
            mul_b = {1'b0, kz_ff};
         end
         ST_S0: begin
            mul_a = acc_ff[47:16];
            mul_b = MUL_B_W'(level_scale_ff);
         end
         ST_S1: begin
            mul_a = MUL_A_W'(h_lo_ff);
            mul_b = MUL_B_W'(level_scale_ff);
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // Sequencer and datapath next state
   always_comb begin
      state_in       = state_ff;
      x_vertices_in  = x_vertices_ff;
      z_vertices_in  = z_vertices_ff;
      level_scale_in = level_scale_ff;
      xf_in          = xf_ff;
      zf_in          = zf_ff;
      ix0_in         = ix0_ff;
      ix1_in         = ix1_ff;
      iz0_in         = iz0_ff;
      iz1_in         = iz1_ff;
      kx_in          = kx_ff;
      kz_in          = kz_ff;
      h0_in          = h0_ff;
      h1_in          = h1_ff;
      h_lo_in        = h_lo_ff;
      acc_in         = acc_ff;
      height_in      = height_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;

      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            CSR_X_VERTICES:  x_vertices_in  = csr_ch.data[VERTEX_W-1:0];
            CSR_Z_VERTICES:  z_vertices_in  = csr_ch.data[VERTEX_W-1:0];
            CSR_LEVEL_SCALE: level_scale_in = csr_ch.data[SCALE_W-1:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_ch.kind == KIND_QUERY)) begin
               // fractions above one saturate to one
               xf_in    = (req_ch.x_fraction > ONE_Q16) ? ONE_Q16 : req_ch.x_fraction;
               zf_in    = (req_ch.z_fraction > ONE_Q16) ? ONE_Q16 : req_ch.z_fraction;
               state_in = ST_LOCX;
            end
         end
         ST_LOCX: begin
            ix0_in   = loc_lo_c;
            ix1_in   = loc_hi;
            kx_in    = mul_p[15:0];
            state_in = ST_LOCZ;
         end
         ST_LOCZ: begin
            iz0_in   = loc_lo_c;
            iz1_in   = loc_hi;
            kz_in    = mul_p[15:0];
            state_in = ST_RD00;
         end
         ST_RD00: begin
            state_in = ST_RD01;
         end
         ST_RD01: begin
            acc_in   = mul_p;
            state_in = ST_RD10;
         end
         ST_RD10: begin
            acc_in   = acc_ff + mul_p;
            state_in = ST_RD11;
         end
         ST_RD11: begin
            h0_in    = acc_ff[31:0];  // lower row blend, Q16.16
            acc_in   = mul_p;
            state_in = ST_X11;
         end
         ST_X11: begin
            acc_in   = acc_ff + mul_p;
            state_in = ST_Z0;
         end
         ST_Z0: begin
            h1_in    = acc_ff[31:0];  // upper row blend, Q16.16
            acc_in   = mul_p;
            state_in = ST_Z1;
         end
         ST_Z1: begin
            acc_in   = acc_ff + mul_p;  // h, Q16.32, below 2^48
            state_in = ST_S0;
         end
         ST_S0: begin
            // (h * s) >> 32 == (hi32 * s + ((lo16 * s) >> 16)) >> 16
            h_lo_in  = acc_ff[15:0];
            acc_in   = mul_p;
            state_in = ST_S1;
         end
         ST_S1: begin
            acc_in   = acc_ff + ACC_W'(mul_p[PROD_W-1:16]);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               height_in    = acc_ff[47:16];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         x_vertices_ff  <= VERTICES_RESET;
         z_vertices_ff  <= VERTICES_RESET;
         level_scale_ff <= LEVEL_SCALE_RESET;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         x_vertices_ff  <= x_vertices_in;
         z_vertices_ff  <= z_vertices_in;
         level_scale_ff <= level_scale_in;
      end
   end

   always_ff @(posedge clock) begin
      xf_ff     <= xf_in;
      zf_ff     <= zf_in;
      ix0_ff    <= ix0_in;
      ix1_ff    <= ix1_in;
      iz0_ff    <= iz0_in;
      iz1_ff    <= iz1_in;
      kx_ff     <= kx_in;
      kz_ff     <= kz_in;
      h0_ff     <= h0_in;
      h1_ff     <= h1_in;
      h_lo_ff   <= h_lo_in;
      acc_ff    <= acc_in;
      height_ff <= height_in;
   end

   // A query blocks further transactions until it is done
   a_query_blocks: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_ch.kind == KIND_QUERY) |=> !req_ch.ready)
      else $error("req_ch ready right after a query");

   // Grid writes never land while a query uses the RAM port
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_IDLE))
      else $error("grid write outside idle");

   // Upper x corner is lower corner or one above, inside the grid
   a_x_corners: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOCZ) |-> (ix1_ff >= ix0_ff) && (ix1_ff <= x_cells))
      else $error("x corners out of order");

   // A finished query with a free output slot presents its result
   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && out_free |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("result not loaded");

endmodule

### tb/tb_bilinear_height_grid_sampler.sv
module tb_bilinear_height_grid_sampler;
   import bhgs_pkg::*;

   localparam int unsigned GRID_SIDE    = MAX_SIDE_DEFAULT;
   // A query holds the block until it is done; leave margin before any CSR write.
   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int unsigned LONG_HOLD     = 400;
   // CSR index with no register behind it
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef struct {
      logic                kind;
      logic [INDEX_W-1:0]  row;
      logic [INDEX_W-1:0]  column;
      logic [HEIGHT_W-1:0] raw_height;
      logic [FRAC_W-1:0]   x_fraction;
      logic [FRAC_W-1:0]   z_fraction;
   } grid_item_type;

   logic clock = 1'b0;
   logic reset;

   bhgs_req_if req_ch ();
   bhgs_rsp_if rsp_ch ();
   bhgs_csr_if csr_ch ();

   bilinear_height_grid_sampler dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #2 clock = ~clock;

   // Shadow of the CSRs, updated at the CSR handshake.
   logic [VERTEX_W-1:0] cfg_x_vertices = VERTICES_RESET;
   logic [VERTEX_W-1:0] cfg_z_vertices = VERTICES_RESET;
   logic [SCALE_W-1:0]  cfg_level_scale = LEVEL_SCALE_RESET;

   // grid_heights mirrors the RAM as transactions are accepted.
   // grid_written tracks entries already queued for writing, so queries are
   // only generated once every neighbor they read is sure to be defined.
   logic [HEIGHT_W-1:0] grid_heights [int unsigned];
   bit                  grid_written [int unsigned];

   grid_item_type       pending_items [$];
   logic [RESULT_W-1:0] expected_heights [$];

   grid_item_type       req_item;
   bit                  req_busy = 1'b0;   // mirrors req_ch.valid
   int                  send_idle_pct = 0;
   int                  recv_stall_pct = 0;
   int                  rsp_hold_left = 0;
   int                  fail_count = 0;
   logic [RESULT_W-1:0] height_exp;

   // ------------------------------------------------------------------
   // Height predictor
   // ------------------------------------------------------------------

   // Cell count = vertex count saturated to 2..GRID_SIDE, minus one.
   function automatic logic [VERTEX_W-1:0] cell_count(input logic [VERTEX_W-1:0] v);
      if (v < 2) return 11'd1;
      if (32'(v) > GRID_SIDE) return VERTEX_W'(GRID_SIDE - 1);
      return v - 1'b1;
   endfunction

   // Lower corner, clamped upper corner and Q0.16 weight of one axis.
   function automatic void locate_corner(input logic [FRAC_W-1:0] frac,
                                         input logic [VERTEX_W-1:0] cells,
                                         output logic [INDEX_W-1:0] lo,
                                         output logic [INDEX_W-1:0] hi,
                                         output logic [15:0] weight);
      logic [FRAC_W-1:0] f;
      logic [27:0]       p;
      f = (frac > ONE_Q16) ? ONE_Q16 : frac;   // fractions above one saturate
      p = 28'(f) * 28'(cells);
      lo = p[26:16];
      weight = p[15:0];
      if (lo > cells) lo = cells;
      hi = (32'(lo) + 1 > 32'(cells)) ? cells : INDEX_W'(lo + 1'b1);
   endfunction

   function automatic logic [63:0] grid_value(input logic [INDEX_W-1:0] r,
                                              input logic [INDEX_W-1:0] c);
      int unsigned key;
      key = 32'(r) * GRID_SIDE + 32'(c);
      if (grid_heights.exists(key)) return 64'(grid_heights[key]);
      return 64'd0;
   endfunction

   // Exact bilinear blend (Q16.32), times Q8.8 scale, one truncation to Q24.8.
   function automatic logic [RESULT_W-1:0] predict_height(input logic [FRAC_W-1:0] xf,
                                                          input logic [FRAC_W-1:0] zf);
      logic [INDEX_W-1:0] ix0, ix1, iz0, iz1;
      logic [15:0]        kx, kz;
      logic [63:0]        h0, h1, h, scaled;
      locate_corner(xf, cell_count(cfg_x_vertices), ix0, ix1, kx);
      locate_corner(zf, cell_count(cfg_z_vertices), iz0, iz1, kz);
      h0 = grid_value(iz0, ix0) * (64'd65536 - 64'(kx)) + grid_value(iz0, ix1) * 64'(kx);
      h1 = grid_value(iz1, ix0) * (64'd65536 - 64'(kx)) + grid_value(iz1, ix1) * 64'(kx);
      h = h0 * (64'd65536 - 64'(kz)) + h1 * 64'(kz);
      scaled = (h * 64'(cfg_level_scale)) >> 32;
      return scaled[RESULT_W-1:0];
   endfunction

   // ------------------------------------------------------------------
   // Stimulus generation
   // ------------------------------------------------------------------

   task automatic queue_write(input logic [INDEX_W-1:0] r, input logic [INDEX_W-1:0] c,
                              input logic [HEIGHT_W-1:0] h);
      grid_item_type it;
      it.kind = KIND_WRITE;
      it.row = r;
      it.column = c;
      it.raw_height = h;
      it.x_fraction = FRAC_W'($urandom_range(131071));   // don't-care payload
      it.z_fraction = FRAC_W'($urandom_range(131071));
      pending_items.push_back(it);
      if (32'(r) < GRID_SIDE && 32'(c) < GRID_SIDE)
         grid_written[32'(r) * GRID_SIDE + 32'(c)] = 1'b1;
   endtask

   task automatic fill_if_unwritten(input logic [INDEX_W-1:0] r,
                                    input logic [INDEX_W-1:0] c);
      if (!grid_written.exists(32'(r) * GRID_SIDE + 32'(c)))
         queue_write(r, c, HEIGHT_W'($urandom));
   endtask

   // Queue a query, preceded by writes of any neighbor not yet defined.
   task automatic queue_query(input logic [FRAC_W-1:0] xf, input logic [FRAC_W-1:0] zf);
      logic [INDEX_W-1:0] ix0, ix1, iz0, iz1;
      logic [15:0]        kx, kz;
      grid_item_type      it;
      locate_corner(xf, cell_count(cfg_x_vertices), ix0, ix1, kx);
      locate_corner(zf, cell_count(cfg_z_vertices), iz0, iz1, kz);
      fill_if_unwritten(iz0, ix0);
      fill_if_unwritten(iz0, ix1);
      fill_if_unwritten(iz1, ix0);
      fill_if_unwritten(iz1, ix1);
      it.kind = KIND_QUERY;
      it.row = INDEX_W'($urandom);
      it.column = INDEX_W'($urandom);
      it.raw_height = HEIGHT_W'($urandom);
      it.x_fraction = xf;
      it.z_fraction = zf;
      pending_items.push_back(it);
   endtask

   function automatic logic [FRAC_W-1:0] random_fraction();
      case ($urandom_range(19))
         0:       return '0;
         1:       return ONE_Q16;
         2, 3:    return FRAC_W'($urandom_range(131071, 65537));   // above one
         default: return FRAC_W'($urandom_range(65536));
      endcase
   endfunction

   // Mostly queries on the active grid, writes spread over it, a few
   // writes off the grid edge that the block must drop. The count covers
   // the neighbor writes that queries pull in.
   task automatic queue_random(input int count);
      logic [INDEX_W-1:0] r, c;
      int                 pick;
      int                 stop;
      stop = pending_items.size() + count;
      while (pending_items.size() < stop) begin
         if ($urandom_range(99) < 55) begin
            queue_query(random_fraction(), random_fraction());
         end else begin
            pick = $urandom_range(9);
            if (pick < 7) begin
               r = INDEX_W'($urandom_range(32'(cell_count(cfg_z_vertices))));
               c = INDEX_W'($urandom_range(32'(cell_count(cfg_x_vertices))));
            end else if (pick < 9) begin
               r = INDEX_W'($urandom_range(GRID_SIDE - 1));
               c = INDEX_W'($urandom_range(GRID_SIDE - 1));
            end else if ($urandom_range(1)) begin
               r = INDEX_W'($urandom_range(2047, GRID_SIDE));
               c = INDEX_W'($urandom);
            end else begin
               r = INDEX_W'($urandom);
               c = INDEX_W'($urandom_range(2047, GRID_SIDE));
            end
            queue_write(r, c, HEIGHT_W'($urandom));
         end
      end
   endtask

   // ------------------------------------------------------------------
   // CSR writes and phase control (main initial block only)
   // ------------------------------------------------------------------

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      case (idx)
         CSR_X_VERTICES:  cfg_x_vertices = value[VERTEX_W-1:0];
         CSR_Z_VERTICES:  cfg_z_vertices = value[VERTEX_W-1:0];
         CSR_LEVEL_SCALE: cfg_level_scale = value[SCALE_W-1:0];
         default: ;   // unmapped index, no effect
      endcase
   endtask

   // Wait until every transaction is taken and every height returned, then
   // let a trailing write or query settle before the block is reconfigured.
   task automatic drain();
      while (pending_items.size() != 0 || req_busy || expected_heights.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] xv, input logic [CSR_DATA_W-1:0] zv,
                            input logic [CSR_DATA_W-1:0] scale, input int send_pct,
                            input int recv_pct, input int count);
      write_csr(CSR_X_VERTICES, xv);
      write_csr(CSR_Z_VERTICES, zv);
      write_csr(CSR_LEVEL_SCALE, scale);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      queue_random(count);
      drain();
   endtask

   // ------------------------------------------------------------------
   // Request driver: one transaction in flight, popped from pending_items.
   // The predictor runs at the accepting edge with the current CSR shadow.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_busy = 1'b0;
         req_ch.valid <= 1'b0;
      end else begin
         if (req_busy && req_ch.ready) begin
            if (req_item.kind == KIND_WRITE) begin
               // Off-grid writes are dropped; beyond the vertex counts they stick.
               if (32'(req_item.row) < GRID_SIDE && 32'(req_item.column) < GRID_SIDE)
                  grid_heights[32'(req_item.row) * GRID_SIDE + 32'(req_item.column)] =
                     req_item.raw_height;
            end else begin
               expected_heights.push_back(predict_height(req_item.x_fraction,
                                                         req_item.z_fraction));
            end
            req_busy = 1'b0;
         end
         if (!req_busy && pending_items.size() != 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            req_item = pending_items.pop_front();
            req_busy = 1'b1;
            req_ch.kind       <= req_item.kind;
            req_ch.row        <= req_item.row;
            req_ch.column     <= req_item.column;
            req_ch.raw_height <= req_item.raw_height;
            req_ch.x_fraction <= req_item.x_fraction;
            req_ch.z_fraction <= req_item.z_fraction;
         end
         req_ch.valid <= req_busy;
      end
   end

   // ------------------------------------------------------------------
   // Response monitor: compare against the oldest expected height. The
   // long hold-off is counted here and overrides the random stall.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_heights.size() == 0) begin
               $error("height: expected none, actual %0d", rsp_ch.height);
               fail_count++;
            end else begin
               height_exp = expected_heights.pop_front();
               if (rsp_ch.height !== height_exp) begin
                  $error("height: expected %0d, actual %0d", height_exp, rsp_ch.height);
                  fail_count++;
               end
            end
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_WRITE;
      req_ch.row = '0;
      req_ch.column = '0;
      req_ch.raw_height = '0;
      req_ch.x_fraction = '0;
      req_ch.z_fraction = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_X_VERTICES;
      csr_ch.data = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset CSR values (full 1025 x 1025 grid, scale 1.0).
      queue_write(11'd0, 11'd0, 16'h0000);
      queue_write(11'd0, 11'd1, 16'hFFFF);
      queue_write(11'd1, 11'd0, 16'd12345);
      queue_write(11'd1, 11'd1, 16'hFFFF);
      queue_write(11'd1024, 11'd1024, 16'hFFFF);
      queue_write(11'd1023, 11'd1023, 16'h8000);
      queue_write(11'd1023, 11'd1024, 16'h0001);
      queue_write(11'd1024, 11'd1023, 16'hABCD);
      // Off-grid writes: dropped.
      queue_write(11'd1025, 11'd3, 16'h1111);
      queue_write(11'd5, 11'd2047, 16'h2222);
      queue_write(11'd2047, 11'd2047, 16'h3333);
      queue_query(17'd0, 17'd0);
      queue_query(17'd32, 17'd32);         // half weight, lower cells
      queue_query(ONE_Q16, ONE_Q16);       // upper corner clamps to last vertex
      queue_query(17'h1FFFF, 17'h1FFFF);   // saturates to one
      queue_query(17'd65535, 17'd65535);   // just below one
      queue_query(17'd64, 17'd65535);
      drain();

      // Smallest grid, largest scale, all-max heights for the top of range.
      write_csr(CSR_X_VERTICES, 16'd2);
      write_csr(CSR_Z_VERTICES, 16'd2);
      write_csr(CSR_LEVEL_SCALE, 16'hFFFF);
      queue_write(11'd0, 11'd0, 16'hFFFF);
      queue_write(11'd0, 11'd1, 16'hFFFF);
      queue_write(11'd1, 11'd0, 16'hFFFF);
      queue_write(11'd1, 11'd1, 16'hFFFF);
      queue_query(17'd32768, 17'd32768);
      queue_query(ONE_Q16, 17'd0);
      queue_write(11'd500, 11'd700, 16'h5A5A);   // outside the vertex counts, still stored
      queue_random(150);
      drain();

      // Vertex counts below two saturate; zero scale; unmapped CSR index.
      write_csr(CSR_UNMAPPED, CSR_DATA_W'($urandom));
      run_phase(16'd0, 16'd1, 16'd0, 82, 0, 100);

      // Upper bits masked off: 0xFFFF -> 2047 -> saturates to 1025.
      run_phase(16'hFFFF, 16'd1025, CSR_DATA_W'($urandom), 0, 82, 250);

      run_phase(CSR_DATA_W'($urandom_range(40, 2)), CSR_DATA_W'($urandom_range(40, 2)),
                CSR_DATA_W'($urandom), 33, 33, 300);

      // Back-pressure: receiver holds off while the sender keeps offering.
      write_csr(CSR_X_VERTICES, 16'd5);
      write_csr(CSR_Z_VERTICES, 16'd7);
      write_csr(CSR_LEVEL_SCALE, CSR_DATA_W'($urandom));
      send_idle_pct = 0;
      recv_stall_pct = 0;
      rsp_hold_left = int'(LONG_HOLD);
      queue_random(200);
      drain();

      // 0xF802 masks to 2.
      run_phase(16'd1024, 16'hF802, 16'd256, 82, 0, 150);
      run_phase(CSR_DATA_W'($urandom_range(1025, 2)), CSR_DATA_W'($urandom_range(1025, 2)),
                CSR_DATA_W'($urandom), 0, 0, 300);
      run_phase(16'd17, 16'd1025, 16'hFFFF, 0, 82, 200);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();

      if (fail_count == 0) begin
         $display("tb_bilinear_height_grid_sampler: PASS");
      end else begin
         $display("tb_bilinear_height_grid_sampler: FAIL");
      end
      $finish;
   end

   // Watchdog: well beyond the slowest legal run.
   initial begin
      #4000000;
      $display("tb_bilinear_height_grid_sampler: FAIL");
      $finish;
   end

endmodule
